// ===== rtl/core/sms_pkg.sv =====
package sms_pkg;

	localparam logic [7:0] MK_FIRST  = 8'h2A;
	localparam logic [7:0] MK_SECOND = 8'h04;
	localparam logic [7:0] PAIR_A    = 8'h55;
	localparam logic [7:0] PAIR_B    = 8'hE2;
	localparam logic [7:0] ZERO_BYTE = 8'h00;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
	} out_t;

	typedef struct packed {
		logic seam_shape;
		logic newest_first;
	} hist_flags_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} step_t;

	typedef struct packed {
		logic  take_in;
		logic  walk;
		step_t on_done;
		step_t on_more;
	} ucode_t;

	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		unique case (s)
			ST_IDLE: begin
				w = '{take_in: 1'b1, walk: 1'b0, on_done: ST_IDLE, on_more: ST_EMIT};
			end
			ST_EMIT: begin
				w = '{take_in: 1'b0, walk: 1'b1, on_done: ST_IDLE, on_more: ST_EMIT};
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/sms_history.sv =====
module sms_history #(
	parameter int LOOKBACK = 12
) (
	input  logic                              clk,
	input  logic                              push,
	input  logic [7:0]                        push_byte,
	input  logic [$clog2(LOOKBACK+2)-1:0]     rd_idx,
	output logic [7:0]                        rd_byte,
	output sms_pkg::hist_flags_t              flags
);
	import sms_pkg::*;

	localparam int DEPTH = LOOKBACK + 2;

	logic [7:0] hist_q [0:DEPTH-1];
	logic       pair_hit;

	always_ff @(posedge clk) begin
		if (push) begin
			hist_q[0] <= push_byte;
			for (int i = 1; i < DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	assign rd_byte = hist_q[rd_idx];

	always_comb begin
		pair_hit = 1'b0;
		for (int a = 2; a <= LOOKBACK; a++) begin
			if (hist_q[a] == PAIR_A && hist_q[a-1] == PAIR_B) begin
				pair_hit = 1'b1;
			end
		end
		flags.seam_shape   = pair_hit && hist_q[1] == ZERO_BYTE && hist_q[2] == ZERO_BYTE;
		flags.newest_first = hist_q[0] == MK_FIRST;
	end

endmodule

// ===== rtl/core/seam_marker_stripper_core.sv =====
// Seam marker stripper: removes 0x2A 0x04 seam markers and the bytes around them from a byte
// stream. The first result byte of an input transaction is loaded into the output register
// in the same cycle as the transaction is taken; each further result byte of that transaction
// takes one more step, because a two-step microcoded sequencer walks the history register one
// byte per step into the single output register. In steady flow each byte taken in sends one
// byte out. A seam, a released run of held bytes or the end of the stream has up to LOOKBACK+2
// result bytes, and the input is stalled while they are sent. Output stall holds the
// sequencer. A final byte with nothing to send produces one empty end transaction.
module seam_marker_stripper_core #(
	parameter int LOOKBACK  = 12,
	parameter int SKIP_SPAN = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_stall,
	input  sms_pkg::in_t  src_data,
	output logic          dst_valid,
	input  logic          dst_stall,
	output sms_pkg::out_t dst_data
);
	import sms_pkg::*;

	localparam int HDEPTH = LOOKBACK + 1;
	localparam int CW     = $clog2(LOOKBACK + 2);
	localparam int SW     = $clog2(SKIP_SPAN);

	step_t       step_q, step_d;
	ucode_t      uw;
	hist_flags_t flags;

	logic [CW-1:0] pending_q, pending_d;
	logic [CW-1:0] seg_q, seg_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [SW-1:0] skip_q, skip_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] lo_q, lo_d;
	logic          last_q, last_d;
	logic          ovalid_q, ovalid_d;
	out_t          out_q, out_d;

	logic          out_free, accept, advance, done, have;
	logic          is_marker;
	logic [CW-1:0] hi, lo;
	logic [CW-1:0] rd_idx;
	logic [7:0]    rd_byte;

	sms_history #(.LOOKBACK(LOOKBACK)) u_hist (
		.clk       (clk),
		.push      (accept),
		.push_byte (src_data.in_byte),
		.rd_idx    (rd_idx),
		.rd_byte   (rd_byte),
		.flags     (flags)
	);

	assign uw        = ucode_rom(step_q);
	assign out_free  = !ovalid_q || !dst_stall;
	assign src_stall = !(uw.take_in && out_free);
	assign accept    = src_valid && !src_stall;
	assign dst_valid = ovalid_q;
	assign dst_data  = out_q;

	always_comb begin
		pending_d = pending_q;
		seg_d     = seg_q;
		skip_d    = skip_q;
		fill_d    = (fill_q == CW'(HDEPTH)) ? fill_q : fill_q + CW'(1);
		have      = 1'b0;
		hi        = pending_q;
		lo        = '0;
		is_marker = src_data.in_byte == MK_SECOND && pending_q != '0 && flags.newest_first;

		priority if (skip_q != '0) begin
			skip_d = skip_q - SW'(1);
		end else if (is_marker) begin
			if (fill_q == CW'(HDEPTH) && flags.seam_shape) begin
				have   = seg_q != CW'(HDEPTH) && pending_q > CW'(1);
				lo     = CW'(2);
				skip_d = SW'(SKIP_SPAN - 2);
			end else begin
				have = 1'b1;
			end
			pending_d = '0;
			seg_d     = '0;
		end else begin
			if (pending_q == CW'(HDEPTH)) begin
				have = 1'b1;
				lo   = src_data.in_last ? '0 : CW'(HDEPTH);
			end else begin
				have      = src_data.in_last;
				pending_d = pending_q + CW'(1);
			end
			if (seg_q != CW'(HDEPTH)) begin
				seg_d = seg_q + CW'(1);
			end
		end

		if (src_data.in_last) begin
			pending_d = '0;
			seg_d     = '0;
			skip_d    = '0;
			fill_d    = '0;
		end
	end

	always_comb begin
		rd_idx = uw.walk ? idx_q : ((hi == '0) ? '0 : hi - CW'(1));

		out_d    = out_q;
		ovalid_d = ovalid_q && dst_stall;
		idx_d    = idx_q;
		lo_d     = lo_q;
		last_d   = last_q;
		done     = 1'b1;
		advance  = 1'b0;

		if (uw.take_in) begin
			advance = accept;
			done    = !have || hi == lo;
			if (accept) begin
				idx_d  = hi - CW'(1);
				lo_d   = lo;
				last_d = src_data.in_last;
				if (have) begin
					out_d.out_byte  = (hi == '0) ? src_data.in_byte : rd_byte;
					out_d.out_valid = 1'b1;
					out_d.out_last  = src_data.in_last && hi == lo;
					ovalid_d        = 1'b1;
				end else if (src_data.in_last) begin
					out_d.out_byte  = ZERO_BYTE;
					out_d.out_valid = 1'b0;
					out_d.out_last  = 1'b1;
					ovalid_d        = 1'b1;
				end
			end
		end else if (uw.walk) begin
			advance = out_free;
			done    = idx_q == lo_q;
			if (out_free) begin
				idx_d           = idx_q - CW'(1);
				out_d.out_byte  = rd_byte;
				out_d.out_valid = 1'b1;
				out_d.out_last  = last_q && idx_q == lo_q;
				ovalid_d        = 1'b1;
			end
		end

		step_d = advance ? (done ? uw.on_done : uw.on_more) : step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= ST_IDLE;
			ovalid_q  <= 1'b0;
			pending_q <= '0;
			seg_q     <= '0;
			fill_q    <= '0;
			skip_q    <= '0;
		end else begin
			step_q   <= step_d;
			ovalid_q <= ovalid_d;
			if (accept) begin
				pending_q <= pending_d;
				seg_q     <= seg_d;
				fill_q    <= fill_d;
				skip_q    <= skip_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		out_q  <= out_d;
		idx_q  <= idx_d;
		lo_q   <= lo_d;
		last_q <= last_d;
	end

endmodule
